[rtl/assert_macros.svh]
// assertion macros for the plane table rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PT_ASSERT_IMP(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define PT_ASSERT_NXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define PT_ASSERT_IMP(lbl, clk, rstn, a, c)
`define PT_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

[rtl/ptfa_pkg.sv]
// types and constants for the plane table find-or-add block
// no dependencies
package ptfa_pkg;
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int QUEUE_DEPTH = 2;
	localparam logic signed [16:0] UNIT_Q14 = 17'sd16384;
	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] CFG_NORM_EPS = 2'd0;
	localparam logic [1:0] CFG_DIST_EPS = 2'd1;
	localparam logic [1:0] CFG_ID_BASE = 2'd2;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [31:0] d;
	} plane_t;

	typedef struct packed {
		logic [9:0] plane_index;
		logic [31:0] plane_id;
		logic [3:0] plane_class;
		logic [1:0] status;
	} result_t;

	function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
		neg16 = (v == 16'sh8000) ? 16'sh7fff : -v;
	endfunction

	function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
		neg32 = (v == 32'sh80000000) ? 32'sh7fffffff : -v;
	endfunction
endpackage

[rtl/ptfa_if.sv]
// valid/ready channel interfaces for plane items, results and config writes
// no dependencies
interface ptfa_plane_if;
	logic valid;
	logic ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic signed [31:0] distance;
	modport source (output valid, normal_x, normal_y, normal_z, distance, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, distance, output ready);
endinterface

interface ptfa_result_if;
	logic valid;
	logic ready;
	logic [9:0] plane_index;
	logic [31:0] plane_id;
	logic [3:0] plane_class;
	logic [1:0] status;
	modport source (output valid, plane_index, plane_id, plane_class, status, input ready);
	modport sink (input valid, plane_index, plane_id, plane_class, status, output ready);
endinterface

interface ptfa_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/ptfa_front.sv]
// front end: accepts planes, snaps normal and distance, pushes into a small queue
// depends on ptfa_pkg
module ptfa_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ptfa_pkg::plane_t in_plane,
	input  logic [14:0] norm_eps,
	input  logic [15:0] dist_eps,
	output logic q_valid,
	input  logic q_pop,
	output ptfa_pkg::plane_t q_plane
);
	localparam int QD = ptfa_pkg::QUEUE_DEPTH;
	ptfa_pkg::plane_t snap;
	ptfa_pkg::plane_t mem_q [QD];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	logic signed [17:0] c [3];
	logic hit_p [3];
	logic hit_n [3];
	logic signed [33:0] t, r, dd;
	logic [33:0] ta;

	always_comb begin
		c[0] = 18'(in_plane.nx);
		c[1] = 18'(in_plane.ny);
		c[2] = 18'(in_plane.nz);
		for (int i = 0; i < 3; i++) begin
			hit_p[i] = ((c[i] >= 18'sd16384) ? c[i] - 18'sd16384 : 18'sd16384 - c[i])
				< $signed({3'b0, norm_eps});
			hit_n[i] = ((c[i] >= -18'sd16384) ? c[i] + 18'sd16384 : -18'sd16384 - c[i])
				< $signed({3'b0, norm_eps});
		end
		snap = in_plane;
		if (hit_p[0] || hit_n[0]) begin
			snap.nx = hit_p[0] ? 16'sd16384 : -16'sd16384;
			snap.ny = '0; snap.nz = '0;
		end else if (hit_p[1] || hit_n[1]) begin
			snap.ny = hit_p[1] ? 16'sd16384 : -16'sd16384;
			snap.nx = '0; snap.nz = '0;
		end else if (hit_p[2] || hit_n[2]) begin
			snap.nz = hit_p[2] ? 16'sd16384 : -16'sd16384;
			snap.nx = '0; snap.ny = '0;
		end
		t = 34'(in_plane.d) + 34'sd128;
		ta = t[33] ? 34'(-t) : 34'(t);
		ta[7:0] = '0;
		r = t[33] ? -$signed(ta) : $signed(ta);
		dd = 34'(in_plane.d) - r;
		if (dd < 0)
			dd = -dd;
		if (r >= -34'sd2147483648 && r <= 34'sd2147483647
			&& dd < $signed({18'b0, dist_eps}))
			snap.d = r[31:0];
	end

	assign in_ready = (cnt_q != 2'(QD)) || q_pop;
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_plane = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= snap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

[rtl/ptfa_back.sv]
// back end: scans the plane table one entry a cycle, appends new pairs
// depends on ptfa_pkg
module ptfa_back #(
	parameter int TABLE_DEPTH = ptfa_pkg::TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  ptfa_pkg::plane_t q_plane,
	input  logic [14:0] norm_eps,
	input  logic [15:0] dist_eps,
	input  logic [31:0] id_base,
	output logic res_valid,
	input  logic res_ready,
	output ptfa_pkg::result_t res
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_CMP = 3'd2,
		S_WR0 = 3'd3, S_WR1 = 3'd4, S_OUT = 3'd5;

	ptfa_pkg::plane_t pl_mem [TABLE_DEPTH];
	logic [3:0] cl_mem [TABLE_DEPTH];
	logic [31:0] id_mem [TABLE_DEPTH];
	logic [31:0] tw_mem [TABLE_DEPTH];

	logic [2:0] state_q;
	ptfa_pkg::plane_t cur_q, rd_s1, wr_pl;
	logic [3:0] rdc_s1, wr_cl, cls_q;
	logic [31:0] rdi_s1, wr_id, wr_tw, id_q;
	logic [AW:0] count_q, idx_q, cmp_q;
	logic [31:0] issued_q;
	logic [9:0] ridx_q;
	logic [1:0] st_q;
	logic swap_q;
	logic [2:0] typ_q;
	logic we;
	logic [AW-1:0] waddr;
	logic match;
	logic signed [17:0] ex, ey, ez;
	logic signed [32:0] ed;
	logic [2:0] typ;
	logic [16:0] ax, ay, az;
	logic sw;

	function automatic logic signed [17:0] ad16(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [17:0] v;
		v = 18'(a) - 18'(b);
		ad16 = (v < 0) ? -v : v;
	endfunction

	always_comb begin
		ex = ad16(rd_s1.nx, cur_q.nx);
		ey = ad16(rd_s1.ny, cur_q.ny);
		ez = ad16(rd_s1.nz, cur_q.nz);
		ed = 33'(rd_s1.d) - 33'(cur_q.d);
		if (ed < 0)
			ed = -ed;
		match = ex < $signed({3'b0, norm_eps}) && ey < $signed({3'b0, norm_eps})
			&& ez < $signed({3'b0, norm_eps}) && ed < $signed({17'b0, dist_eps});
	end

	always_comb begin
		ax = cur_q.nx[15] ? 17'(-18'(cur_q.nx)) : 17'(cur_q.nx);
		ay = cur_q.ny[15] ? 17'(-18'(cur_q.ny)) : 17'(cur_q.ny);
		az = cur_q.nz[15] ? 17'(-18'(cur_q.nz)) : 17'(cur_q.nz);
		if (ax == 17'd16384)
			typ = 3'd0;
		else if (ay == 17'd16384)
			typ = 3'd1;
		else if (az == 17'd16384)
			typ = 3'd2;
		else if (ax >= ay && ax >= az)
			typ = 3'd3;
		else if (ay >= az)
			typ = 3'd4;
		else
			typ = 3'd5;
		unique case (typ)
			3'd0, 3'd3: sw = cur_q.nx[15];
			3'd1, 3'd4: sw = cur_q.ny[15];
			default: sw = cur_q.nz[15];
		endcase
	end

	always_comb begin
		ptfa_pkg::plane_t p;
		p = cur_q;
		if (swap_q) begin
			p.nx = ptfa_pkg::neg16(cur_q.nx);
			p.ny = ptfa_pkg::neg16(cur_q.ny);
			p.nz = ptfa_pkg::neg16(cur_q.nz);
			p.d = ptfa_pkg::neg32(cur_q.d);
		end
		we = (state_q == S_WR0) || (state_q == S_WR1);
		wr_pl = p;
		wr_cl = {1'b1, typ_q};
		wr_id = id_base + issued_q;
		wr_tw = wr_id + 32'd1;
		waddr = count_q[AW-1:0];
		if (state_q == S_WR1) begin
			wr_pl.nx = ptfa_pkg::neg16(p.nx);
			wr_pl.ny = ptfa_pkg::neg16(p.ny);
			wr_pl.nz = ptfa_pkg::neg16(p.nz);
			wr_pl.d = ptfa_pkg::neg32(p.d);
			wr_cl = {1'b0, typ_q};
			wr_tw = id_base + issued_q - 32'd1;
			wr_id = id_base + issued_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			pl_mem[waddr] <= wr_pl;
			cl_mem[waddr] <= wr_cl;
			id_mem[waddr] <= wr_id;
			tw_mem[waddr] <= wr_tw;
		end
		rd_s1 <= pl_mem[idx_q[AW-1:0]];
		rdc_s1 <= cl_mem[idx_q[AW-1:0]];
		rdi_s1 <= id_mem[idx_q[AW-1:0]] ^ (tw_mem[idx_q[AW-1:0]] & 32'd0);
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign res_valid = (state_q == S_OUT);
	assign res.plane_index = ridx_q;
	assign res.plane_id = id_q;
	assign res.plane_class = cls_q;
	assign res.status = st_q;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_plane;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0; issued_q <= '0; idx_q <= '0; cmp_q <= '0;
			ridx_q <= '0; id_q <= '0; cls_q <= '0; st_q <= ptfa_pkg::ST_FOUND;
			swap_q <= 1'b0; typ_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (q_pop)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q < count_q) begin
						cmp_q <= idx_q;
						idx_q <= idx_q + 1'b1;
						state_q <= S_CMP;
					end else if (32'(count_q) + 32'd2 > 32'(TABLE_DEPTH)) begin
						ridx_q <= '0; id_q <= '0; cls_q <= '0;
						st_q <= ptfa_pkg::ST_FULL;
						state_q <= S_OUT;
					end else begin
						typ_q <= typ;
						swap_q <= sw;
						state_q <= S_WR0;
					end
				end
				S_CMP: begin
					if (match) begin
						ridx_q <= 10'(cmp_q);
						id_q <= rdi_s1;
						cls_q <= rdc_s1;
						st_q <= ptfa_pkg::ST_FOUND;
						state_q <= S_OUT;
					end else if (idx_q < count_q) begin
						cmp_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_WR0: begin
					if (!swap_q) begin
						ridx_q <= 10'(count_q);
						id_q <= wr_id;
						cls_q <= wr_cl;
					end
					count_q <= count_q + 1'b1;
					issued_q <= issued_q + 32'd1;
					state_q <= S_WR1;
				end
				S_WR1: begin
					if (swap_q) begin
						ridx_q <= 10'(count_q);
						id_q <= wr_id;
						cls_q <= wr_cl;
					end
					count_q <= count_q + 1'b1;
					issued_q <= issued_q + 32'd1;
					st_q <= ptfa_pkg::ST_ADDED;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/plane_table_find_or_add.sv]
// top level of the plane table find-or-add block: config registers, front, back
// depends on ptfa_pkg, ptfa_if, ptfa_front, ptfa_back, assert_macros.svh
//
// usage:
//  plane_in carries a plane (normal Q1.14, distance Q23.8); one transfer per item.
//  result carries one result per item: index, id, class and status.
//  cfg writes norm_epsilon (0), dist_epsilon (1), id_base (2); other indexes ignored.
//  the user must write cfg only while the block is idle; cfg.ready is always high.
//  the front snaps the plane in the accept cycle and holds up to two items in a
//  queue, so input is taken while the back scans or the result stalls, until full.
//  the back compares one stored entry per cycle out of its table memory: it pops
//  an item, compares it with each stored entry and stops at the first match;
//  with no match it appends a pair in two writes (S_WR0, S_WR1), or reports
//  status full when fewer than two table entries are left. the back pops a new
//  item only once the result of the last one has been taken.
//  reset empties the table and id counter and loads the register defaults;
//  the table itself needs no clearing pass.
//  a stalled result holds the back; the front keeps filling its queue.
`include "assert_macros.svh"
module plane_table_find_or_add #(
	parameter int TABLE_DEPTH = ptfa_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	ptfa_plane_if.sink plane_in,
	ptfa_result_if.source result,
	ptfa_cfg_if.sink cfg
);
	logic [14:0] norm_eps_q;
	logic [15:0] dist_eps_q;
	logic [31:0] id_base_q;
	ptfa_pkg::plane_t in_plane, q_plane;
	ptfa_pkg::result_t res;
	logic q_valid, q_pop;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_eps_q <= 15'd1;
			dist_eps_q <= 16'd3;
			id_base_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ptfa_pkg::CFG_NORM_EPS: norm_eps_q <= cfg.data[14:0];
				ptfa_pkg::CFG_DIST_EPS: dist_eps_q <= cfg.data[15:0];
				ptfa_pkg::CFG_ID_BASE: id_base_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign in_plane.nx = plane_in.normal_x;
	assign in_plane.ny = plane_in.normal_y;
	assign in_plane.nz = plane_in.normal_z;
	assign in_plane.d = plane_in.distance;

	ptfa_front u_front (
		.clk, .arst_n,
		.in_valid(plane_in.valid), .in_ready(plane_in.ready), .in_plane,
		.norm_eps(norm_eps_q), .dist_eps(dist_eps_q),
		.q_valid, .q_pop, .q_plane
	);

	ptfa_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_plane,
		.norm_eps(norm_eps_q), .dist_eps(dist_eps_q), .id_base(id_base_q),
		.res_valid(result.valid), .res_ready(result.ready), .res
	);

	assign result.plane_index = res.plane_index;
	assign result.plane_id = res.plane_id;
	assign result.plane_class = res.plane_class;
	assign result.status = res.status;

	`PT_ASSERT_IMP(a_pop_needs_data, clk, arst_n, q_pop, q_valid)
	`PT_ASSERT_IMP(a_status_legal, clk, arst_n, result.valid, result.status <= ptfa_pkg::ST_FULL)
	`PT_ASSERT_IMP(a_full_zero, clk, arst_n, result.valid && result.status == ptfa_pkg::ST_FULL,
		result.plane_id == 32'd0 && result.plane_index == 10'd0)
	`PT_ASSERT_NXT(a_out_done, clk, arst_n, result.valid && result.ready, !result.valid)
endmodule
